// File: rtl/mi3_pkg.sv
// Shared constants for the 3x3 matrix inverse block.
package mi3_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int N_ELEM         = 9;

endpackage

// File: rtl/mi3_if.sv
// Valid/ready channel interfaces for the matrix input and the inverse output.
interface mi3_in_if #(
  parameter int DW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] in_r0c0;
  logic signed [DW-1:0] in_r0c1;
  logic signed [DW-1:0] in_r0c2;
  logic signed [DW-1:0] in_r1c0;
  logic signed [DW-1:0] in_r1c1;
  logic signed [DW-1:0] in_r1c2;
  logic signed [DW-1:0] in_r2c0;
  logic signed [DW-1:0] in_r2c1;
  logic signed [DW-1:0] in_r2c2;

  modport source (
    output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    input  ready
  );
  modport sink (
    input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    output ready
  );
endinterface

interface mi3_out_if #(
  parameter int DW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] out_r0c0;
  logic signed [DW-1:0] out_r0c1;
  logic signed [DW-1:0] out_r0c2;
  logic signed [DW-1:0] out_r1c0;
  logic signed [DW-1:0] out_r1c1;
  logic signed [DW-1:0] out_r1c2;
  logic signed [DW-1:0] out_r2c0;
  logic signed [DW-1:0] out_r2c1;
  logic signed [DW-1:0] out_r2c2;
  logic                 singular;

  modport source (
    output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, singular,
    input  ready
  );
  modport sink (
    input  valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, singular,
    output ready
  );
endinterface

// File: rtl/mi3_cofactor.sv
// Cofactor and determinant pipeline: products, cross terms, split det multiply, sum.
module mi3_cofactor #(
  parameter int DW = 32
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [DW-1:0]   m   [mi3_pkg::N_ELEM],
  output logic signed [2*DW:0]   cof [mi3_pkg::N_ELEM],
  output logic signed [3*DW:0]   det
);
  import mi3_pkg::*;

  localparam int PW   = 2 * DW;
  localparam int CW   = 2 * DW + 1;
  localparam int HW   = DW + 1;
  localparam int PPW  = 2 * DW + 1;
  localparam int DETW = 3 * DW + 1;

  logic signed [PW-1:0]   prod_a [N_ELEM];
  logic signed [PW-1:0]   prod_b [N_ELEM];
  logic signed [CW-1:0]   cof2   [N_ELEM];
  logic signed [CW-1:0]   cof3   [N_ELEM];
  logic signed [DW-1:0]   a1     [3];
  logic signed [DW-1:0]   a2     [3];
  logic signed [PPW-1:0]  plo    [3];
  logic signed [PPW-1:0]  phi    [3];

  // Row r of the inverse is the cross product of columns r+1 and r+2.
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_comp
      localparam int PC  = (r + 1) % 3;
      localparam int QC  = (r + 2) % 3;
      localparam int I1  = (k + 1) % 3;
      localparam int I2  = (k + 2) % 3;
      localparam int IDX = r * 3 + k;

      always_ff @(posedge clk) begin
        if (en) begin
          prod_a[IDX] <= PW'(m[I1*3+PC]) * PW'(m[I2*3+QC]);
          prod_b[IDX] <= PW'(m[I2*3+PC]) * PW'(m[I1*3+QC]);
          cof2[IDX]   <= CW'(prod_a[IDX]) - CW'(prod_b[IDX]);
          cof3[IDX]   <= cof2[IDX];
          cof[IDX]    <= cof3[IDX];
        end
      end
    end
  end

  // The determinant multiply is split so that each product stays near DW by DW.
  for (genvar k = 0; k < 3; k++) begin : g_det
    logic signed [HW-1:0] lo_s;
    logic signed [HW-1:0] hi_s;
    assign lo_s = $signed({1'b0, cof2[k][DW-1:0]});
    assign hi_s = $signed(cof2[k][CW-1:DW]);

    always_ff @(posedge clk) begin
      if (en) begin
        a1[k]  <= m[k*3];
        a2[k]  <= a1[k];
        plo[k] <= PPW'(a2[k]) * PPW'(lo_s);
        phi[k] <= PPW'(a2[k]) * PPW'(hi_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= (DETW'(phi[0]) <<< DW) + DETW'(plo[0])
           + (DETW'(phi[1]) <<< DW) + DETW'(plo[1])
           + (DETW'(phi[2]) <<< DW) + DETW'(plo[2]);
    end
  end

endmodule

// File: rtl/mi3_div_lane.sv
// One divider lane: rounded, saturated cofactor * 2^(2F) / det, one quotient bit a stage.
module mi3_div_lane #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [2*DW:0] cof,
  input  logic signed [3*DW:0] det,
  output logic [DW-1:0]        res
);

  localparam int CW   = 2 * DW + 1;
  localparam int CMW  = 2 * DW;
  localparam int DETW = 3 * DW + 1;
  localparam int DMW  = 3 * DW;
  localparam int NA   = 2 * DW + 2 * FB + 1;
  localparam int NUMW = ((NA > DMW) ? NA : DMW) + 1;
  localparam int DENW = DMW + 1;
  localparam int WW   = (NUMW > DENW + DW) ? NUMW : DENW + DW;

  logic [CW-1:0]   cof_abs;
  logic [DETW-1:0] det_abs;
  logic [CMW-1:0]  cm;
  logic [DMW-1:0]  dm;

  logic [NUMW-1:0] num_a;
  logic [DENW-1:0] den_a;
  logic            neg_a;

  logic [WW-1:0]   rem  [DW+1];
  logic [DENW-1:0] den2 [DW+1];
  logic [DW-1:0]   quo  [DW+1];
  logic            neg  [DW+1];
  logic            ovf  [DW+1];

  logic [DW-1:0]   lim;
  logic [DW-1:0]   qv;

  assign cof_abs = cof[CW-1] ? (~cof + 1'b1) : cof;
  assign det_abs = det[DETW-1] ? (~det + 1'b1) : det;
  assign cm      = cof_abs[CMW-1:0];
  assign dm      = det_abs[DMW-1:0];

  // Rounding to nearest, ties away from zero: (2|N| + |D|) / (2|D|).
  always_ff @(posedge clk) begin
    if (en) begin
      num_a <= (NUMW'(cm) << (2 * FB + 1)) + NUMW'(dm);
      den_a <= DENW'(dm) << 1;
      neg_a <= cof[CW-1] ^ det[DETW-1];
    end
  end

  // A quotient of 2^DW or more saturates whatever its low bits are.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= WW'(num_a);
      den2[0] <= den_a;
      quo[0]  <= '0;
      neg[0]  <= neg_a;
      ovf[0]  <= WW'(num_a) >= (WW'(den_a) << DW);
    end
  end

  for (genvar j = 1; j <= DW; j++) begin : g_bit
    localparam int K = DW - j;
    logic [WW-1:0] dsh;
    logic          take;
    assign dsh  = WW'(den2[j-1]) << K;
    assign take = rem[j-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= take ? (rem[j-1] - dsh) : rem[j-1];
        quo[j]  <= quo[j-1] | (DW'(take) << K);
        den2[j] <= den2[j-1];
        neg[j]  <= neg[j-1];
        ovf[j]  <= ovf[j-1];
      end
    end
  end

  assign lim = neg[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  assign qv  = (ovf[DW] || (quo[DW] > lim)) ? lim : quo[DW];
  assign res = neg[DW] ? (~qv + 1'b1) : qv;

endmodule

// File: rtl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse: cofactor pipeline, nine divider lanes, merge.
//
//   channel | modport | transaction
//   in_ch   | sink    | nine signed elements of one matrix
//   out_ch  | source  | nine inverse elements and the singular flag
//
// One matrix is taken every cycle while no finished result is stalled on out_ch;
// each result passes the cofactor stages, one divider stage per quotient bit in
// each lane and the merge register. The whole pipeline advances together and
// freezes while a finished result waits on out_ch. Reset clears only the valid bits.
module matrix3x3_inverse #(
  parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  mi3_in_if.sink   in_ch,
  mi3_out_if.source out_ch
);
  import mi3_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int LAT  = DW + 7;
  localparam int SDN  = DW + 2;

  logic                   en;
  logic [LAT-1:0]         vld;
  logic signed [DW-1:0]   m     [N_ELEM];
  logic signed [2*DW:0]   cof   [N_ELEM];
  logic signed [3*DW:0]   det;
  logic [DW-1:0]          res   [N_ELEM];
  logic [SDN-1:0]         sd;
  logic [DW-1:0]          out_q [N_ELEM];
  logic                   sing_q;

  assign en          = !vld[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign m[0] = in_ch.in_r0c0;
  assign m[1] = in_ch.in_r0c1;
  assign m[2] = in_ch.in_r0c2;
  assign m[3] = in_ch.in_r1c0;
  assign m[4] = in_ch.in_r1c1;
  assign m[5] = in_ch.in_r1c2;
  assign m[6] = in_ch.in_r2c0;
  assign m[7] = in_ch.in_r2c1;
  assign m[8] = in_ch.in_r2c2;

  mi3_cofactor #(.DW(DW)) u_cofactor (
    .clk (clk),
    .en  (en),
    .m   (m),
    .cof (cof),
    .det (det)
  );

  for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
    mi3_div_lane #(.DW(DW), .FB(FRAC_BITS)) u_lane (
      .clk (clk),
      .en  (en),
      .cof (cof[i]),
      .det (det),
      .res (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  // The singular flag travels beside the lanes and zeroes the merged result.
  always_ff @(posedge clk) begin
    if (en) begin
      sd     <= {sd[SDN-2:0], (det == '0)};
      sing_q <= sd[SDN-1];
      for (int i = 0; i < N_ELEM; i++) begin
        out_q[i] <= sd[SDN-1] ? '0 : res[i];
      end
    end
  end

  assign out_ch.valid    = vld[LAT-1];
  assign out_ch.singular = sing_q;
  assign out_ch.out_r0c0 = out_q[0];
  assign out_ch.out_r0c1 = out_q[1];
  assign out_ch.out_r0c2 = out_q[2];
  assign out_ch.out_r1c0 = out_q[3];
  assign out_ch.out_r1c1 = out_q[4];
  assign out_ch.out_r1c2 = out_q[5];
  assign out_ch.out_r2c0 = out_q[6];
  assign out_ch.out_r2c1 = out_q[7];
  assign out_ch.out_r2c2 = out_q[8];

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the 3x3 adjugate matrix inverse with saturated Q16.16 output.
module testbench;
  import mi3_pkg::*;

  localparam int DW    = DATA_WIDTH_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam int WIDE  = 192;
  localparam int LIMIT = 4000;
  localparam int LATENCY = DW + 7;
  localparam int RAND_PER_PHASE = 375;

  typedef logic [N_ELEM-1:0][DW-1:0] matrix_t;
  typedef struct packed {
    logic [N_ELEM-1:0][DW-1:0] elem;
    logic                      singular;
  } inverse_t;

  logic clk;
  logic rst;

  mi3_in_if  #(.DW(DW)) in_ch ();
  mi3_out_if #(.DW(DW)) out_ch ();

  matrix3x3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  inverse_t pending_inverses[$];
  int       sender_idle_pct;
  int       receiver_stall_pct;
  int       error_count;
  int       matrices_sent;
  int       inverses_checked;
  int       singular_seen;
  int       quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounded, saturated cofactor * 2^(2F) / det, as a DW-bit pattern.
  function automatic logic [DW-1:0] scaled_quotient(logic signed [WIDE-1:0] cofactor,
                                                    logic signed [WIDE-1:0] det);
    logic signed [WIDE-1:0] num;
    logic [WIDE-1:0]        abs_num;
    logic [WIDE-1:0]        abs_det;
    logic [WIDE-1:0]        quo;
    logic [WIDE-1:0]        lim;
    logic                   neg;
    num     = cofactor <<< (2 * FB);
    neg     = (num < 0) != (det < 0);
    abs_num = (num < 0) ? -num : num;
    abs_det = (det < 0) ? -det : det;
    quo     = (2 * abs_num + abs_det) / (2 * abs_det);
    lim     = neg ? (WIDE'(1) << (DW - 1)) : ((WIDE'(1) << (DW - 1)) - 1);
    if (quo > lim) quo = lim;
    if (neg) quo = -quo;
    return quo[DW-1:0];
  endfunction

  function automatic inverse_t predict_inverse(matrix_t m);
    logic signed [WIDE-1:0] col[3][3];
    logic signed [WIDE-1:0] adj[3][3];
    logic signed [WIDE-1:0] det;
    inverse_t               res;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        col[c][r] = $signed(m[r*3+c]);
    // Row i of the adjugate is the cross product of the other two columns.
    for (int i = 0; i < 3; i++) begin
      int p, q;
      p = (i + 1) % 3;
      q = (i + 2) % 3;
      adj[i][0] = col[p][1] * col[q][2] - col[p][2] * col[q][1];
      adj[i][1] = col[p][2] * col[q][0] - col[p][0] * col[q][2];
      adj[i][2] = col[p][0] * col[q][1] - col[p][1] * col[q][0];
    end
    det = col[0][0] * adj[0][0] + col[0][1] * adj[0][1] + col[0][2] * adj[0][2];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
    end else begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          res.elem[r*3+c] = scaled_quotient(adj[r][c], det);
    end
    return res;
  endfunction

  task automatic send_matrix(matrix_t m);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_r0c0 <= m[0];
    in_ch.in_r0c1 <= m[1];
    in_ch.in_r0c2 <= m[2];
    in_ch.in_r1c0 <= m[3];
    in_ch.in_r1c1 <= m[4];
    in_ch.in_r1c2 <= m[5];
    in_ch.in_r2c0 <= m[6];
    in_ch.in_r2c1 <= m[7];
    in_ch.in_r2c2 <= m[8];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_inverses.push_back(predict_inverse(m));
    matrices_sent++;
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] fixed(int whole);
    return DW'(whole) << FB;
  endfunction

  function automatic logic [DW-1:0] random_element(int kind);
    case (kind)
      0: return $urandom();
      1: return DW'($signed($urandom_range(8 << FB)) - (4 << FB));
      2: return DW'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(1) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind;
    int      shape;
    kind  = $urandom_range(9);
    kind  = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
    shape = $urandom_range(9);
    for (int i = 0; i < N_ELEM; i++) m[i] = random_element(kind);
    case (shape)
      // Repeated row or column gives a zero determinant; shape 2 keeps only the diagonal.
      0: begin m[6] = m[0]; m[7] = m[1]; m[8] = m[2]; end
      1: begin m[2] = m[1]; m[5] = m[4]; m[8] = m[7]; end
      2: begin m[1] = '0; m[2] = '0; m[3] = '0; m[5] = '0; m[6] = '0; m[7] = '0; end
      default: ;
    endcase
    return m;
  endfunction

  task automatic test_directed();
    matrix_t m;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    m = '0; m[0] = fixed(1); m[4] = fixed(1); m[8] = fixed(1);
    send_matrix(m);
    m = '0; m[0] = fixed(2); m[4] = fixed(-4); m[8] = fixed(8);
    send_matrix(m);
    m = '0; m[1] = fixed(1); m[5] = fixed(1); m[6] = fixed(1);
    send_matrix(m);
    send_matrix('0);
    m = '1;
    send_matrix(m);
    for (int i = 0; i < N_ELEM; i++) m[i] = {1'b0, {(DW-1){1'b1}}};
    send_matrix(m);
    for (int i = 0; i < N_ELEM; i++) m[i] = {1'b1, {(DW-1){1'b0}}};
    send_matrix(m);
    // Tiny diagonal: the inverse saturates high and low.
    m = '0; m[0] = 1; m[4] = 1; m[8] = 1;
    send_matrix(m);
    m = '0; m[0] = '1; m[4] = 1; m[8] = 1;
    send_matrix(m);
    m = '0; m[0] = {1'b1, {(DW-1){1'b0}}}; m[4] = {1'b0, {(DW-1){1'b1}}};
    m[8] = {1'b1, {(DW-1){1'b0}}};
    send_matrix(m);
    m = '0; m[0] = fixed(3); m[4] = fixed(3); m[8] = fixed(3);
    send_matrix(m);
    m = '0; m[0] = fixed(1); m[1] = fixed(2); m[2] = fixed(3);
    m[3] = fixed(4); m[4] = fixed(5); m[5] = fixed(6);
    m[6] = fixed(7); m[7] = fixed(8); m[8] = fixed(10);
    send_matrix(m);
    m[8] = fixed(9);
    send_matrix(m);
    m = '0; m[0] = 32'h5555_5555; m[4] = 32'hAAAA_AAAA; m[8] = 32'h0001_8000;
    m[1] = 32'h0000_0001; m[3] = 32'hFFFF_FFFF;
    send_matrix(m);
    wait_for_drain();
  endtask

  task automatic test_random(int src_pct, int snk_pct);
    sender_idle_pct    = src_pct;
    receiver_stall_pct = snk_pct;
    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      send_matrix(random_matrix());
      if (n == RAND_PER_PHASE / 2) wait_for_drain();
    end
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    inverse_t got;
    inverse_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.elem[0] = out_ch.out_r0c0;
      got.elem[1] = out_ch.out_r0c1;
      got.elem[2] = out_ch.out_r0c2;
      got.elem[3] = out_ch.out_r1c0;
      got.elem[4] = out_ch.out_r1c1;
      got.elem[5] = out_ch.out_r1c2;
      got.elem[6] = out_ch.out_r2c0;
      got.elem[7] = out_ch.out_r2c1;
      got.elem[8] = out_ch.out_r2c2;
      got.singular = out_ch.singular;
      if (pending_inverses.size() == 0) begin
        $error("unexpected output transaction");
        error_count++;
      end else begin
        want = pending_inverses.pop_front();
        for (int i = 0; i < N_ELEM; i++)
          if (got.elem[i] !== want.elem[i]) begin
            $error("out_r%0dc%0d: expected %h, got %h", i / 3, i % 3,
                   want.elem[i], got.elem[i]);
            error_count++;
          end
        if (got.singular !== want.singular) begin
          $error("singular: expected %b, got %b", want.singular, got.singular);
          error_count++;
        end
        inverses_checked++;
        if (want.singular) singular_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_r0c0 = '0; in_ch.in_r0c1 = '0; in_ch.in_r0c2 = '0;
    in_ch.in_r1c0 = '0; in_ch.in_r1c1 = '0; in_ch.in_r1c2 = '0;
    in_ch.in_r2c0 = '0; in_ch.in_r2c1 = '0; in_ch.in_r2c2 = '0;
    error_count = 0;
    matrices_sent = 0;
    inverses_checked = 0;
    singular_seen = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(0, 0);
    test_random(86, 0);
    test_random(0, 86);
    test_random(16, 16);
    repeat (LATENCY + 20) @(posedge clk);
    if (pending_inverses.size() != 0) begin
      $error("%0d inverses never arrived", pending_inverses.size());
      error_count++;
    end
    $display("Sent %0d matrices and checked %0d inverses, %0d of them singular,",
             matrices_sent, inverses_checked, singular_seen);
    $display("under four sender and receiver throttling profiles.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
